// File: rtl/smpq_pkg.sv
// Package of shared constants, types and status codes for the stable minimum priority queue.
package smpq_pkg;

	// Storage geometry.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths of the words on the two channels.
	localparam int PRIO_W   = 8;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Command codes.
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_SERVED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// One stored entry.
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// Access request from the sequencer to the entry store.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

// File: rtl/smpq_req_if.sv
// Channel interface that carries command words into the queue.
interface smpq_req_if import smpq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [PRIO_W-1:0] priority_req;
	logic [TAG_W-1:0]  tag;

	modport source (output valid, cmd, priority_req, tag, input ready);
	modport sink   (input valid, cmd, priority_req, tag, output ready);
endinterface

// File: rtl/smpq_rsp_if.sv
// Channel interface that carries result words out of the queue.
interface smpq_rsp_if import smpq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [TAG_W-1:0]    out_tag;
	logic [PRIO_W-1:0]   out_priority;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
	modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

// File: rtl/stable_min_priority_queue_unit.sv
// Stable minimum priority queue: sequencer, shared compare unit and output register.
// Insert, rejected insert and empty extract go from acceptance to the done state, then to the output register.
// Extract scans the held entries for the winner, then closes the gap behind it; the single
// store read port paces this, one entry per cycle for the scan and for the gap close.
// One command word is worked on at a time; the next is taken once the result is queued.
// Reset clears the occupancy and all control state; stored entries stay undefined.
module stable_min_priority_queue_unit import smpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	smpq_req_if.sink   req,
	smpq_rsp_if.source rsp
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  src_q;
	entry_t            best_q;
	logic [IDX_W-1:0]  best_idx_q;
	status_t           res_status_q;
	entry_t            res_entry_q;
	logic              out_valid_q;
	status_t           out_status_q;
	entry_t            out_entry_q;
	logic [OCC_W-1:0]  out_occ_q;

	mem_req_t          mreq;
	entry_t            rdata;
	logic              accept;
	logic [CNT_W-1:0]  cur_idx;
	logic              take;
	entry_t            best_nx;
	logic [IDX_W-1:0]  best_idx_nx;
	logic              scan_last;
	logic [CNT_W-1:0]  shift_src_nx;
	logic [CNT_W-1:0]  src_inc;
	logic              out_load;

	smpq_store u_store (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// Shared compare unit: the word just read against the best so far; earliest wins ties.
	always_comb begin
		cur_idx      = ptr_q - CNT_W'(1);
		take         = (cur_idx == '0) || (rdata.prio < best_q.prio);
		best_nx      = take ? rdata : best_q;
		best_idx_nx  = take ? cur_idx[IDX_W-1:0] : best_idx_q;
		scan_last    = (ptr_q == count_q);
		shift_src_nx = CNT_W'(best_idx_nx) + CNT_W'(1);
		src_inc      = src_q + CNT_W'(1);
	end

	// Store access for the current step.
	always_comb begin
		mreq       = '0;
		mreq.waddr = count_q[IDX_W-1:0];
		mreq.wdata = '{prio: req.priority_req, tag: req.tag};
		unique case (state_q)
			S_IDLE: begin
				mreq.we    = accept && (req.cmd == CMD_INSERT) &&
				             (count_q != CNT_W'(CAPACITY));
				mreq.raddr = '0;
			end
			S_SCAN: begin
				if (!scan_last) begin
					mreq.raddr = ptr_q[IDX_W-1:0];
				end else begin
					mreq.raddr = shift_src_nx[IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				mreq.we    = 1'b1;
				mreq.waddr = IDX_W'(src_q - CNT_W'(1));
				mreq.wdata = rdata;
				mreq.raddr = src_inc[IDX_W-1:0];
			end
			S_DONE: begin
				mreq.raddr = '0;
			end
			default: begin
				mreq.raddr = '0;
			end
		endcase
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Sequencer with its registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			src_q        <= '0;
			best_idx_q   <= '0;
			res_status_q <= ST_INSERTED;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_INSERTED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_entry_q <= '0;
						if (req.cmd == CMD_INSERT) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_INSERTED;
								count_q      <= count_q + CNT_W'(1);
							end
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							res_status_q <= ST_EMPTY;
							state_q      <= S_DONE;
						end else begin
							ptr_q   <= CNT_W'(1);
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					best_q     <= best_nx;
					best_idx_q <= best_idx_nx;
					if (!scan_last) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end else if (shift_src_nx < count_q) begin
						src_q   <= shift_src_nx;
						state_q <= S_SHIFT;
					end else begin
						count_q      <= count_q - CNT_W'(1);
						res_status_q <= ST_SERVED;
						res_entry_q  <= best_nx;
						state_q      <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (src_inc < count_q) begin
						src_q <= src_inc;
					end else begin
						count_q      <= count_q - CNT_W'(1);
						res_status_q <= ST_SERVED;
						res_entry_q  <= best_q;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Output register: loads from the finished result, frees when taken.
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_entry_q  <= res_entry_q;
				out_occ_q    <= OCC_W'(count_q);
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.out_tag      = out_entry_q.tag;
	assign rsp.out_priority = out_entry_q.prio;
	assign rsp.occupancy    = out_occ_q;

endmodule

// File: rtl/smpq_store.sv
// Entry store: one write port and one read port with registered read data.
module smpq_store import smpq_pkg::*; (
	input  logic     clk,
	input  mem_req_t mreq,
	output entry_t   rdata
);

	entry_t mem [CAPACITY];
	entry_t rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
		rdata_q <= mem[mreq.raddr];
	end

	assign rdata = rdata_q;

endmodule
